// ----- hdl/phim_pkg.sv -----
`default_nettype none
package phim_pkg;
  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_MCAST = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RETRY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;
  localparam logic CFG_CORE_COUNT = 1'b0;
  localparam logic CFG_ENABLED    = 1'b1;
  localparam logic [7:0] ENABLED_RESET = 8'hff;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  core_id;
    logic        run_here;
    logic        raise_interrupt;
    logic [63:0] entry;
    logic [63:0] argument;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// ----- hdl/per_hart_ipi_task_mailbox_top.sv -----
// a single send registers its result in S_SEND; an invalid request or an empty
// drain answers straight from idle, in the cycle after start; multicast checks one
// candidate core per cycle in S_MCAST, from core 0 up to the last selected core
// drain: each entry passes S_DRAIN_RD, S_DRAIN_ST, S_DRAIN_DATA and is then shown
// busy falls in the cycle after the last result; the receiver cannot stall
// sync active-low reset frees slots, clears pointers and irqs, enables all 8 cores
`default_nettype none
module per_hart_ipi_task_mailbox_top #(
  parameter int MAX_CORES = 8,
  parameter int SLOTS_PER_CORE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_requester_core,
  input  wire logic [2:0]  in_target_core,
  input  wire logic [7:0]  in_core_select_mask,
  input  wire logic [3:0]  in_mask_base,
  input  wire logic [63:0] in_task_entry,
  input  wire logic [63:0] in_task_argument,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [2:0]       out_core_id,
  output logic             out_run_here,
  output logic             out_raise_interrupt,
  output logic [63:0]      out_out_entry,
  output logic [63:0]      out_out_argument,
  output logic             out_last
);
  localparam int SW = (SLOTS_PER_CORE > 1) ? $clog2(SLOTS_PER_CORE) : 1;
  localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int DEPTH = MAX_CORES * SLOTS_PER_CORE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(SLOTS_PER_CORE + 1);
  localparam int MCW = $clog2(MAX_CORES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_MCAST, S_DRAIN_RD, S_DRAIN_ST, S_DRAIN_DATA
  } state_t;

  state_t state_r;
  logic [3:0] core_count_r;
  logic [7:0] enabled_r;
  logic [SLOTS_PER_CORE-1:0] free_r [MAX_CORES];
  logic [SW-1:0] head_r [MAX_CORES];
  logic [NW-1:0] count_r [MAX_CORES];
  logic [MAX_CORES-1:0] irq_r;

  logic [2:0] req_r, tgt_r;
  logic [63:0] entry_r, arg_r;
  logic [7:0] mask_r;
  logic [2:0] walk_r;
  logic [2:0] lastc_r;
  phim_pkg::result_t res_r;
  logic res_v_r;

  logic [MCW-1:0] n_eff;
  always_comb begin
    if (core_count_r == 4'd0) n_eff = MCW'(1);
    else if (32'(core_count_r) > MAX_CORES) n_eff = MCW'(MAX_CORES);
    else n_eff = MCW'(core_count_r);
  end

  logic [7:0] in_mask_sh;
  logic [7:0] in_mask_lim;
  always_comb begin
    in_mask_sh = 8'(in_core_select_mask << in_mask_base) & enabled_r;
    for (int i = 0; i < 8; i++) begin
      in_mask_lim[i] = in_mask_sh[i] && (i < 32'(n_eff));
    end
  end

  logic [2:0] in_lastc;
  always_comb begin
    in_lastc = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (in_mask_lim[i]) in_lastc = 3'(i);
    end
  end

  // memory ports
  logic st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [127:0] st_wdata, st_rdata;
  logic rg_we;
  logic [AW-1:0] rg_waddr, rg_raddr;
  logic [SW-1:0] rg_wdata, rg_rdata;

  phim_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  phim_ring #(.DEPTH(DEPTH), .AW(AW), .DW(SW)) u_ring (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(rg_raddr), .rdata(rg_rdata)
  );

  // send datapath for target tcore
  logic [CW-1:0] tcore;
  logic [SLOTS_PER_CORE-1:0] tfree;
  logic [SW-1:0] tslot;
  logic [SW-1:0] tpos;
  always_comb begin
    tcore = (state_r == S_MCAST) ? CW'(walk_r) : CW'(tgt_r);
    tfree = free_r[tcore];
    tslot = '0;
    for (int s = SLOTS_PER_CORE - 1; s >= 0; s--) begin
      if (tfree[s]) tslot = SW'(s);
    end
    tpos = SW'((32'(head_r[tcore]) + 32'(count_r[tcore])) % SLOTS_PER_CORE);
  end

  logic do_send;
  logic send_self;
  logic send_full;
  always_comb begin
    send_self = (tgt_r == req_r) && (state_r == S_SEND)
             || (walk_r == req_r) && (state_r == S_MCAST);
    send_full = (tfree == '0);
    do_send = ((state_r == S_SEND) ||
               (state_r == S_MCAST && mask_r[walk_r])) && !send_self && !send_full;
  end

  logic [CW-1:0] rcore;
  assign rcore = CW'(req_r);

  always_comb begin
    st_we = do_send;
    st_waddr = AW'(32'(tcore) * SLOTS_PER_CORE + 32'(tslot));
    st_wdata = {entry_r, arg_r};
    rg_we = do_send;
    rg_waddr = AW'(32'(tcore) * SLOTS_PER_CORE + 32'(tpos));
    rg_wdata = tslot;
    rg_raddr = AW'(32'(rcore) * SLOTS_PER_CORE + 32'(head_r[rcore]));
    st_raddr = AW'(32'(rcore) * SLOTS_PER_CORE + 32'(rg_rdata));
  end

  function automatic phim_pkg::result_t mk(logic [1:0] st, logic [2:0] c, logic run,
      logic irq, logic [63:0] e, logic [63:0] a, logic l);
    phim_pkg::result_t r;
    r.status = st; r.core_id = c; r.run_here = run; r.raise_interrupt = irq;
    r.entry = e; r.argument = a; r.last = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      core_count_r <= 4'd8;
      enabled_r <= phim_pkg::ENABLED_RESET;
      irq_r <= '0;
      res_v_r <= 1'b0;
      for (int c = 0; c < MAX_CORES; c++) begin
        free_r[c] <= '1;
        head_r[c] <= '0;
        count_r[c] <= '0;
      end
    end else begin
      res_v_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          phim_pkg::CFG_CORE_COUNT: core_count_r <= cfg_wdata[3:0];
          phim_pkg::CFG_ENABLED: enabled_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (do_send) begin
        free_r[tcore][tslot] <= 1'b0;
        count_r[tcore] <= count_r[tcore] + NW'(1);
        irq_r[tcore] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            req_r <= in_requester_core; tgt_r <= in_target_core;
            entry_r <= in_task_entry; arg_r <= in_task_argument;
            mask_r <= in_mask_lim; lastc_r <= in_lastc; walk_r <= 3'd0;
            priority if (in_kind == phim_pkg::KIND_SEND) begin
              if (in_target_core != in_requester_core && 32'(in_target_core) >= 32'(n_eff)) begin
                res_r <= mk(phim_pkg::ST_INVALID, in_target_core, 1'b0, 1'b0, '0, '0, 1'b1);
                res_v_r <= 1'b1;
              end else state_r <= S_SEND;
            end else if (in_kind == phim_pkg::KIND_MCAST) begin
              if (32'(in_mask_base) > 32'(n_eff) || in_mask_lim == 8'd0) begin
                res_r <= mk(phim_pkg::ST_INVALID, in_requester_core, 1'b0, 1'b0, '0, '0, 1'b1);
                res_v_r <= 1'b1;
              end else state_r <= S_MCAST;
            end else if (in_kind == phim_pkg::KIND_DRAIN) begin
              if (32'(in_requester_core) >= 32'(n_eff)) begin
                res_r <= mk(phim_pkg::ST_INVALID, in_requester_core, 1'b0, 1'b0, '0, '0, 1'b1);
                res_v_r <= 1'b1;
              end else begin
                irq_r[CW'(in_requester_core)] <= 1'b0;
                if (count_r[CW'(in_requester_core)] == '0) begin
                  res_r <= mk(phim_pkg::ST_EMPTY, in_requester_core, 1'b0, 1'b0, '0, '0, 1'b1);
                  res_v_r <= 1'b1;
                end else state_r <= S_DRAIN_RD;
              end
            end else begin
              res_r <= mk(phim_pkg::ST_INVALID, in_requester_core, 1'b0, 1'b0, '0, '0, 1'b1);
              res_v_r <= 1'b1;
            end
          end
        end
        S_SEND, S_MCAST: begin
          if (state_r == S_SEND || mask_r[walk_r]) begin
            res_v_r <= 1'b1;
            if (send_self)
              res_r <= mk(phim_pkg::ST_OK, 3'(tcore), entry_r != '0, 1'b0, entry_r, arg_r,
                          state_r == S_SEND || walk_r == lastc_r);
            else if (send_full)
              res_r <= mk(phim_pkg::ST_RETRY, 3'(tcore), 1'b0, 1'b0, '0, '0,
                          state_r == S_SEND || walk_r == lastc_r);
            else
              res_r <= mk(phim_pkg::ST_OK, 3'(tcore), 1'b0, 1'b1, entry_r, arg_r,
                          state_r == S_SEND || walk_r == lastc_r);
          end
          walk_r <= walk_r + 3'd1;
          if (state_r == S_SEND || walk_r == lastc_r) state_r <= S_IDLE;
        end
        // ring read, then slot read, then the entry is shown
        S_DRAIN_RD: state_r <= S_DRAIN_ST;
        S_DRAIN_ST: state_r <= S_DRAIN_DATA;
        S_DRAIN_DATA: begin
          res_v_r <= 1'b1;
          res_r <= mk(phim_pkg::ST_OK, req_r, st_rdata[127:64] != '0, 1'b0,
                      st_rdata[127:64], st_rdata[63:0], count_r[rcore] == NW'(1));
          free_r[rcore][rg_rdata] <= 1'b1;
          head_r[rcore] <= SW'((32'(head_r[rcore]) + 1) % SLOTS_PER_CORE);
          count_r[rcore] <= count_r[rcore] - NW'(1);
          state_r <= (count_r[rcore] == NW'(1)) ? S_IDLE : S_DRAIN_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE) || res_v_r;
  assign out_valid = res_v_r;
  assign out_status = res_r.status;
  assign out_core_id = res_r.core_id;
  assign out_run_here = res_r.run_here;
  assign out_raise_interrupt = res_r.raise_interrupt;
  assign out_out_entry = res_r.entry;
  assign out_out_argument = res_r.argument;
  assign out_last = res_r.last;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy && state_r != S_IDLE |-> !res_v_r || !res_r.last)
    else $error("last result while still working");
  a_full_retry: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && res_r.status != phim_pkg::ST_OK |-> res_r.entry == '0 && !res_r.run_here)
    else $error("non-success result carries task");
  a_drain_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN_RD |-> count_r[rcore] != '0)
    else $error("drain of empty ring");
  a_drain_irq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN_DATA |-> !irq_r[rcore])
    else $error("interrupt still pending while draining");
endmodule
`default_nettype wire

// ----- hdl/phim_store.sv -----
`default_nettype none
module phim_store #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [127:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [127:0]  rdata
);
  logic [127:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/phim_ring.sv -----
`default_nettype none
module phim_ring #(
  parameter int DEPTH = 128,
  parameter int AW = 7,
  parameter int DW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- tb/sv/per_hart_ipi_task_mailbox_top_tb.sv -----
`timescale 1ns / 1ps
module per_hart_ipi_task_mailbox_top_tb;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  req;
    logic [2:0]  tgt;
    logic [7:0]  sel;
    logic [3:0]  base;
    logic [63:0] entry;
    logic [63:0] arg;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [2:0]  in_requester_core = '0;
  logic [2:0]  in_target_core = '0;
  logic [7:0]  in_core_select_mask = '0;
  logic [3:0]  in_mask_base = '0;
  logic [63:0] in_task_entry = '0;
  logic [63:0] in_task_argument = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [2:0]  out_core_id;
  logic        out_run_here;
  logic        out_raise_interrupt;
  logic [63:0] out_out_entry;
  logic [63:0] out_out_argument;
  logic        out_last;

  per_hart_ipi_task_mailbox_top uut (.*);

  always #10 clk = ~clk;

  // mailbox predictor state
  logic [3:0]  core_cnt_reg;
  logic [7:0]  enabled_reg;
  logic [15:0] free_mask [8];
  logic [63:0] entry_mem [128];
  logic [63:0] arg_mem [128];
  logic [3:0]  ring_slot [128];
  logic [3:0]  ring_head [8];
  logic [4:0]  ring_cnt [8];

  request_t pending_q [$];
  phim_pkg::result_t mailbox_results_q [$];
  request_t cur;
  int       idle_pct = 8;
  bit       failed = 0;
  int       cycles = 0;

  function automatic int live_cores();
    if (core_cnt_reg == 0) return 1;
    if (core_cnt_reg > 8) return 8;
    return int'(core_cnt_reg);
  endfunction

  task automatic push_result(logic [1:0] st, logic [2:0] core, logic run, logic irq,
                             logic [63:0] e, logic [63:0] a, logic lst);
    phim_pkg::result_t r;
    r.status = st; r.core_id = core; r.run_here = run; r.raise_interrupt = irq;
    r.entry = e; r.argument = a; r.last = lst;
    mailbox_results_q.push_back(r);
  endtask

  task automatic deliver(request_t t, logic [2:0] dst, logic lst);
    int s;
    logic [3:0] pos;
    s = 0;
    if (dst == t.req) begin
      push_result(phim_pkg::ST_OK, dst, t.entry != 0, 1'b0, t.entry, t.arg, lst);
    end else if (free_mask[dst] == 0) begin
      push_result(phim_pkg::ST_RETRY, dst, 1'b0, 1'b0, '0, '0, lst);
    end else begin
      while (!free_mask[dst][s]) s++;
      free_mask[dst][s] = 1'b0;
      entry_mem[dst*16+s] = t.entry;
      arg_mem[dst*16+s] = t.arg;
      pos = ring_head[dst] + ring_cnt[dst][3:0];
      ring_slot[dst*16+pos] = s[3:0];
      ring_cnt[dst]++;
      push_result(phim_pkg::ST_OK, dst, 1'b0, 1'b1, t.entry, t.arg, lst);
    end
  endtask

  task automatic predict_mailbox(request_t t);
    int n, lastc;
    logic [63:0] m;
    logic [3:0] s;
    n = live_cores();
    lastc = -1;
    case (t.kind)
      phim_pkg::KIND_SEND: begin
        if (t.tgt != t.req && t.tgt >= n)
          push_result(phim_pkg::ST_INVALID, t.tgt, 1'b0, 1'b0, '0, '0, 1'b1);
        else
          deliver(t, t.tgt, 1'b1);
      end
      phim_pkg::KIND_MCAST: begin
        m = (64'(t.sel) << t.base) & 64'(enabled_reg);
        for (int i = 0; i < n; i++) if (m[i]) lastc = i;
        if (t.base > n || lastc < 0)
          push_result(phim_pkg::ST_INVALID, t.req, 1'b0, 1'b0, '0, '0, 1'b1);
        else
          for (int i = 0; i < n; i++) if (m[i]) deliver(t, 3'(i), i == lastc);
      end
      phim_pkg::KIND_DRAIN: begin
        if (t.req >= n) begin
          push_result(phim_pkg::ST_INVALID, t.req, 1'b0, 1'b0, '0, '0, 1'b1);
        end else if (ring_cnt[t.req] == 0) begin
          push_result(phim_pkg::ST_EMPTY, t.req, 1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
          while (ring_cnt[t.req] != 0) begin
            s = ring_slot[t.req*16+ring_head[t.req]];
            ring_head[t.req]++;
            ring_cnt[t.req]--;
            free_mask[t.req][s] = 1'b1;
            push_result(phim_pkg::ST_OK, t.req, entry_mem[t.req*16+s] != 0, 1'b0,
                        entry_mem[t.req*16+s], arg_mem[t.req*16+s], ring_cnt[t.req] == 0);
          end
        end
      end
      default: push_result(phim_pkg::ST_INVALID, t.req, 1'b0, 1'b0, '0, '0, 1'b1);
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_mailbox(cur);
      if (!start || !busy) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur = pending_q.pop_front();
          in_kind <= cur.kind;
          in_requester_core <= cur.req;
          in_target_core <= cur.tgt;
          in_core_select_mask <= cur.sel;
          in_mask_base <= cur.base;
          in_task_entry <= cur.entry;
          in_task_argument <= cur.arg;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    phim_pkg::result_t e;
    if (rst_n && out_valid) begin
      if (mailbox_results_q.size() == 0) begin
        $error("unexpected result transaction, status %0d core %0d", out_status, out_core_id);
        failed = 1;
      end else begin
        e = mailbox_results_q.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status); failed = 1;
        end
        if (out_core_id !== e.core_id) begin
          $error("core_id expected %0d actual %0d", e.core_id, out_core_id); failed = 1;
        end
        if (out_run_here !== e.run_here) begin
          $error("run_here expected %0d actual %0d", e.run_here, out_run_here); failed = 1;
        end
        if (out_raise_interrupt !== e.raise_interrupt) begin
          $error("raise_interrupt expected %0d actual %0d", e.raise_interrupt,
                 out_raise_interrupt);
          failed = 1;
        end
        if (out_out_entry !== e.entry) begin
          $error("out_entry expected %h actual %h", e.entry, out_out_entry); failed = 1;
        end
        if (out_out_argument !== e.argument) begin
          $error("out_argument expected %h actual %h", e.argument, out_out_argument);
          failed = 1;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last); failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic request_t mk(logic [1:0] k, logic [2:0] r, logic [2:0] t,
                                  logic [7:0] sl, logic [3:0] b, logic [63:0] e,
                                  logic [63:0] a);
    request_t x;
    x.kind = k; x.req = r; x.tgt = t; x.sel = sl; x.base = b; x.entry = e; x.arg = a;
    return x;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t rand_request();
    request_t x;
    int pick;
    x = mk(2'($urandom_range(3)), 3'($urandom_range(7)), 3'($urandom_range(7)),
           8'($urandom_range(255)),
           4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(3)),
           $urandom_range(9) == 0 ? 64'd0 : rand64(), rand64());
    pick = $urandom_range(99);
    if (pick < 50) x.kind = phim_pkg::KIND_SEND;
    else if (pick < 72) x.kind = phim_pkg::KIND_MCAST;
    else if (pick < 96) x.kind = phim_pkg::KIND_DRAIN;
    else x.kind = phim_pkg::KIND_RSVD;
    if ($urandom_range(2) == 0) x.tgt = 3'd1;
    if (x.kind == phim_pkg::KIND_DRAIN && $urandom_range(1) == 0) x.req = 3'd1;
    return x;
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || mailbox_results_q.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    if (idx == phim_pkg::CFG_CORE_COUNT) core_cnt_reg = v[3:0];
    else enabled_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int cnt, int idle);
    idle_pct = idle;
    repeat (cnt) pending_q.push_back(rand_request());
    wait_quiet();
  endtask

  initial begin
    core_cnt_reg = 4'd8;
    enabled_reg = phim_pkg::ENABLED_RESET;
    for (int c = 0; c < 8; c++) begin
      free_mask[c] = 16'hffff; ring_head[c] = '0; ring_cnt[c] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill core 1 to the brim, then overflow it
    for (int i = 0; i < 16; i++)
      pending_q.push_back(mk(phim_pkg::KIND_SEND, 3'd0, 3'd1, 8'h00, 4'd0,
                             i == 3 ? 64'd0 : (i == 5 ? '1 : 64'(i * 17 + 1)),
                             i == 5 ? '1 : rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_SEND, 3'd7, 3'd1, 8'hff, 4'hf, '1, '1));
    pending_q.push_back(mk(phim_pkg::KIND_MCAST, 3'd2, 3'd0, 8'hff, 4'd0, rand64(), rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_MCAST, 3'd2, 3'd0, 8'hff, 4'd9, rand64(), rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_MCAST, 3'd2, 3'd0, 8'h00, 4'd0, rand64(), rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_DRAIN, 3'd1, 3'd0, 8'h00, 4'd0, '0, '0));
    pending_q.push_back(mk(phim_pkg::KIND_DRAIN, 3'd1, 3'd0, 8'h00, 4'd0, '0, '0));
    pending_q.push_back(mk(phim_pkg::KIND_SEND, 3'd4, 3'd4, 8'h00, 4'd0, '0, rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_RSVD, 3'd5, 3'd2, 8'h81, 4'd8, '1, '1));
    wait_quiet();

    write_reg(phim_pkg::CFG_CORE_COUNT, 8'd4);
    pending_q.push_back(mk(phim_pkg::KIND_SEND, 3'd0, 3'd6, 8'h00, 4'd0, rand64(), rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_DRAIN, 3'd6, 3'd0, 8'h00, 4'd0, '0, '0));
    pending_q.push_back(mk(phim_pkg::KIND_MCAST, 3'd0, 3'd0, 8'h80, 4'd0, rand64(), rand64()));
    pending_q.push_back(mk(phim_pkg::KIND_MCAST, 3'd0, 3'd0, 8'h01, 4'd4, rand64(), rand64()));
    random_phase(30, 8);

    write_reg(phim_pkg::CFG_CORE_COUNT, 8'd0);
    write_reg(phim_pkg::CFG_ENABLED, 8'h00);
    random_phase(20, 56);

    write_reg(phim_pkg::CFG_CORE_COUNT, 8'd15);
    write_reg(phim_pkg::CFG_ENABLED, 8'h5a);
    random_phase(30, 56);

    write_reg(phim_pkg::CFG_CORE_COUNT, 8'd8);
    write_reg(phim_pkg::CFG_ENABLED, 8'hff);
    random_phase(30, 0);

    write_reg(phim_pkg::CFG_CORE_COUNT, 8'd6);
    write_reg(phim_pkg::CFG_ENABLED, 8'ha5);
    random_phase(25, 0);

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/phim_pkg.sv
hdl/phim_store.sv
hdl/phim_ring.sv
hdl/per_hart_ipi_task_mailbox_top.sv
tb/sv/per_hart_ipi_task_mailbox_top_tb.sv
